// ===== sv/gcd_pkg.sv =====
// ============================================================================
// gcd_pkg
// Shared types and constants for the genome compatibility distance block.
// ============================================================================
package gcd_pkg;

    localparam int INNOV_W  = 24;
    localparam int WEIGHT_W = 16;
    localparam int KIND_W   = 4;
    localparam int AW_W     = 16;
    localparam int DIST_W   = 32;
    localparam int MATCH_W  = 9;
    localparam int DISJ_W   = 10;

    localparam logic [AW_W-1:0] ACT_WEIGHT_RESET = 16'd256;

    // request codes
    localparam logic [1:0] REQ_APPEND_A = 2'd0;
    localparam logic [1:0] REQ_APPEND_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE  = 2'd2;

    typedef struct packed {
        logic [INNOV_W-1:0]         innov;
        logic signed [WEIGHT_W-1:0] weight;
        logic [KIND_W-1:0]          kind;
    } gene_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_TAIL,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        TERM_DISJ,
        TERM_WEIGHT,
        TERM_ACT
    } term_t;

    // handshake between sequencer and divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic busy;
    } div_stat_t;

endpackage

// ===== sv/genome_compatibility_distance.sv =====
// Genome compatibility distance.
// Appends: one item per cycle while no compute is running, written straight into list memory A or B.
// Compute: a merge walk over the two lists, then up to three divisions in the
// shared bit-serial divider.
// Result sits in an output register; a new item is taken while it waits.
// Reset (rst_n, async low): lists empty, drop flag clear, activation_weight 1.0.
// ============================================================================
// genome_compatibility_distance
// Merge two innovation-sorted gene lists held in memories and compute the
// compatibility distance in unsigned Q16.16.
// ============================================================================
module genome_compatibility_distance #(
    parameter int MAX_GENES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gcd_pkg::AW_W-1:0]        cfg_data,
    // request items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [gcd_pkg::INNOV_W-1:0]     innovation,
    input  logic signed [gcd_pkg::WEIGHT_W-1:0] gene_weight,
    input  logic [gcd_pkg::KIND_W-1:0]      activation_kind,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gcd_pkg::DIST_W-1:0]      distance,
    output logic [gcd_pkg::MATCH_W-1:0]     matching_count,
    output logic [gcd_pkg::DISJ_W-1:0]      disjoint_count,
    output logic                            both_empty,
    output logic                            dropped
);
    import gcd_pkg::*;

    localparam int CW    = $clog2(MAX_GENES + 1);
    localparam int AW    = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
    localparam int WS_W  = CW + WEIGHT_W;
    localparam int PR_W  = CW + AW_W;
    localparam int DW    = CW + 24;
    localparam int ACC_W = (DW + 2 > DIST_W + 1) ? DW + 2 : DIST_W + 1;

    // list memories, one row per gene
    gene_t mem_a [MAX_GENES];
    gene_t mem_b [MAX_GENES];
    gene_t rd_a_reg, rd_b_reg;

    logic [AW_W-1:0]  act_w_reg;
    logic [CW-1:0]    count_a_reg, count_a_next;
    logic [CW-1:0]    count_b_reg, count_b_next;
    logic             drop_reg, drop_next;

    state_t           state_reg, state_next;
    term_t            term_reg, term_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    match_reg, match_next;
    logic [CW:0]      disj_reg, disj_next;
    logic [CW-1:0]    actd_reg, actd_next;
    logic [WS_W-1:0]  wsum_reg, wsum_next;
    logic [PR_W-1:0]  prod_reg, prod_next;
    logic [CW-1:0]    maxlen_reg, maxlen_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [MATCH_W-1:0]  mcnt_reg, mcnt_next;
    logic [DISJ_W-1:0]   dcnt_reg, dcnt_next;
    logic                empty_reg, empty_next;
    logic                dropo_reg, dropo_next;

    logic             in_acc;
    logic             we_a, we_b;
    gene_t            wr_gene;
    logic signed [WEIGHT_W:0] wdiff;
    logic [WEIGHT_W-1:0]      wabs;

    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [DW-1:0]    div_dividend;
    logic [CW-1:0]    div_divisor;
    logic [DW-1:0]    div_quot;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;

    assign wr_gene.innov  = innovation;
    assign wr_gene.weight = gene_weight;
    assign wr_gene.kind   = activation_kind;

    // drop appends to a full list
    assign we_a = in_acc && (req_type == REQ_APPEND_A) && (count_a_reg != CW'(MAX_GENES));
    assign we_b = in_acc && (req_type == REQ_APPEND_B) && (count_b_reg != CW'(MAX_GENES));

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[count_a_reg[AW-1:0]] <= wr_gene;
        end
        rd_a_reg <= mem_a[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[count_b_reg[AW-1:0]] <= wr_gene;
        end
        rd_b_reg <= mem_b[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_w_reg <= ACT_WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            act_w_reg <= cfg_data;
        end
    end

    // merge step on the two rows just read
    assign wdiff = {rd_a_reg.weight[WEIGHT_W-1], rd_a_reg.weight}
                 - {rd_b_reg.weight[WEIGHT_W-1], rd_b_reg.weight};
    assign wabs  = wdiff[WEIGHT_W] ? WEIGHT_W'(-wdiff) : wdiff[WEIGHT_W-1:0];

    // operands of the current term
    always_comb
    begin
        case (term_reg)
            TERM_DISJ:
            begin
                div_dividend = DW'({disj_reg, 16'b0});
                div_divisor  = maxlen_reg;
            end
            TERM_WEIGHT:
            begin
                div_dividend = DW'({wsum_reg, 4'b0});
                div_divisor  = match_reg;
            end
            TERM_ACT:
            begin
                div_dividend = DW'({prod_reg, 8'b0});
                div_divisor  = match_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = maxlen_reg;
            end
        endcase
    end

    gcd_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        match_next     = match_reg;
        disj_next      = disj_reg;
        actd_next      = actd_reg;
        wsum_next      = wsum_reg;
        prod_next      = prod_reg;
        maxlen_next    = maxlen_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        dist_next      = dist_reg;
        mcnt_next      = mcnt_reg;
        dcnt_next      = dcnt_reg;
        empty_next     = empty_reg;
        dropo_next     = dropo_reg;
        div_ctrl.start = 1'b0;

        // release the result register once the item is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (req_type)
                        REQ_APPEND_A:
                        begin
                            if (we_a)
                                count_a_next = count_a_reg + 1'b1;
                            else
                                drop_next = 1'b1;
                        end
                        REQ_APPEND_B:
                        begin
                            if (we_b)
                                count_b_next = count_b_reg + 1'b1;
                            else
                                drop_next = 1'b1;
                        end
                        REQ_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            match_next = '0;
                            disj_next  = '0;
                            actd_next  = '0;
                            wsum_next  = '0;
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                // memories read rows i and j this cycle
                if (i_reg < count_a_reg && j_reg < count_b_reg)
                    state_next = S_CMP;
                else
                    state_next = S_TAIL;
            end

            S_CMP:
            begin
                if (rd_a_reg.innov == rd_b_reg.innov)
                begin
                    wsum_next  = wsum_reg + WS_W'(wabs);
                    if (rd_a_reg.kind != rd_b_reg.kind)
                        actd_next = actd_reg + 1'b1;
                    match_next = match_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    j_next     = j_reg + 1'b1;
                end
                else if (rd_a_reg.innov < rd_b_reg.innov)
                begin
                    disj_next = disj_reg + 1'b1;
                    i_next    = i_reg + 1'b1;
                end
                else
                begin
                    disj_next = disj_reg + 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                state_next = S_RD;
            end

            S_TAIL:
            begin
                disj_next   = disj_reg + {1'b0, count_a_reg - i_reg}
                                       + {1'b0, count_b_reg - j_reg};
                maxlen_next = (count_a_reg > count_b_reg) ? count_a_reg : count_b_reg;
                prod_next   = act_w_reg * actd_reg;
                acc_next    = '0;
                term_next   = TERM_DISJ;
                if (count_a_reg == '0 && count_b_reg == '0)
                    state_next = S_OUT;
                else
                    state_next = S_DSTART;
            end

            S_DSTART:
            begin
                div_ctrl.start = 1'b1;
                state_next     = S_DWAIT;
            end

            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    acc_next = acc_reg + ACC_W'(div_quot);
                    if (term_reg == TERM_ACT || (term_reg == TERM_DISJ && match_reg == '0))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        term_next  = (term_reg == TERM_DISJ) ? TERM_WEIGHT : TERM_ACT;
                        state_next = S_DSTART;
                    end
                end
            end

            S_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    dist_next  = (|acc_reg[ACC_W-1:DIST_W]) ? '1 : acc_reg[DIST_W-1:0];
                    mcnt_next  = MATCH_W'(match_reg);
                    dcnt_next  = DISJ_W'(disj_reg);
                    empty_next = (maxlen_reg == '0);
                    dropo_next = drop_reg;
                    count_a_next = '0;
                    count_b_next = '0;
                    drop_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg   <= term_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        match_reg  <= match_next;
        disj_reg   <= disj_next;
        actd_reg   <= actd_next;
        wsum_reg   <= wsum_next;
        prod_reg   <= prod_next;
        maxlen_reg <= maxlen_next;
        acc_reg    <= acc_next;
        dist_reg   <= dist_next;
        mcnt_reg   <= mcnt_next;
        dcnt_reg   <= dcnt_next;
        empty_reg  <= empty_next;
        dropo_reg  <= dropo_next;
    end

    assign out_valid      = out_valid_reg;
    assign distance       = dist_reg;
    assign matching_count = mcnt_reg;
    assign disjoint_count = dcnt_reg;
    assign both_empty     = empty_reg;
    assign dropped        = dropo_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= CW'(MAX_GENES) && count_b_reg <= CW'(MAX_GENES))
        else $error("list count beyond capacity");
    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> i_reg < count_a_reg && j_reg < count_b_reg)
        else $error("merge step outside list bounds");
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DWAIT)
        else $error("divider finished while sequencer not waiting");
`endif

endmodule

// ===== sv/gcd_div.sv =====
// ============================================================================
// gcd_div
// Iterative restoring divider, one quotient bit per cycle.
// ============================================================================
module gcd_div #(
    parameter int DW = 40,
    parameter int VW = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcd_pkg::div_ctrl_t   ctrl,
    input  logic [DW-1:0]        dividend,
    input  logic [VW-1:0]        divisor,
    output gcd_pkg::div_stat_t   stat,
    output logic [DW-1:0]        quotient
);
    import gcd_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg;
    logic [DW-1:0]    qd_reg;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [VW:0]      trial;
    logic             ge;
    logic [VW:0]      diff;

    assign trial = {rem_reg, qd_reg[DW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            qd_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
            qd_reg  <= {qd_reg[DW-2:0], ge};
        end
    end

    assign stat.done = done_reg;
    assign stat.busy = busy_reg;
    assign quotient  = qd_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule
